// File: hdl/gsd_pkg.sv
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types and constants for the gripper stall-detect controller.
// ----------------------------------------------------------------------------
package gsd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_OPENING = 2'd1,
    MODE_CLOSING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_OPEN_START    = 3'd1,
    EV_CLOSE_START   = 3'd2,
    EV_OPENED        = 3'd3,
    EV_OPEN_TIMEOUT  = 3'd4,
    EV_STALL_HOLD    = 3'd5,
    EV_CLOSED_REOPEN = 3'd6,
    EV_CLOSE_TIMEOUT = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    OP_COMMAND  = 2'd0,
    OP_SAMPLE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  // Item class handed from the front end to the sequencer
  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_OPEN_CMD  = 3'd1,
    KIND_CLOSE_CMD = 3'd2,
    KIND_OTHER_CMD = 3'd3,
    KIND_SAMPLE    = 3'd4,
    KIND_TICK      = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    REG_CLOSE_CURRENT      = 3'd0,
    REG_HOLD_CURRENT       = 3'd1,
    REG_OPEN_POSITION      = 3'd2,
    REG_CLOSE_POSITION     = 3'd3,
    REG_POSITION_TOLERANCE = 3'd4,
    REG_STALL_CURRENT      = 3'd5,
    REG_OPEN_TIMEOUT       = 3'd6,
    REG_CLOSE_TIMEOUT      = 3'd7
  } cfg_reg_t;

  localparam logic [7:0]  CMD_OPEN  = 8'h31;
  localparam logic [7:0]  CMD_CLOSE = 8'h32;

  localparam logic [10:0] STALL_CURRENT_MARGIN = 11'd10;
  localparam logic [15:0] TICK_MAX             = 16'hFFFF;
  localparam logic [1:0]  STALL_RUN_MAX        = 2'd3;

  localparam logic [10:0] RST_CLOSE_CURRENT      = 11'd111;
  localparam logic [10:0] RST_HOLD_CURRENT       = 11'd111;
  localparam logic [31:0] RST_OPEN_POSITION      = 32'd2800;
  localparam logic [31:0] RST_CLOSE_POSITION     = 32'd700;
  localparam logic [11:0] RST_POSITION_TOLERANCE = 12'd30;
  localparam logic [10:0] RST_STALL_CURRENT      = 11'd800;
  localparam logic [15:0] RST_OPEN_TIMEOUT       = 16'd3000;
  localparam logic [15:0] RST_CLOSE_TIMEOUT      = 16'd60000;

  typedef struct packed {
    logic [10:0] close_current;
    logic [10:0] hold_current;
    logic [31:0] open_position;
    logic [31:0] close_position;
    logic [11:0] position_tolerance;
    logic [10:0] stall_current_limit;
    logic [15:0] open_timeout_ms;
    logic [15:0] close_timeout_ms;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic        stall;
    logic        near_open;
    logic        near_close;
    logic [31:0] position;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [10:0] goal_current;
    logic [31:0] goal_position;
    mode_t       mode_now;
    event_t      event_code;
  } result_t;

endpackage

// File: hdl/gsd_fifo.sv
// ----------------------------------------------------------------------------
// gsd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module gsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/gsd_front.sv
// ----------------------------------------------------------------------------
// gsd_front
// Classifies an incoming item: command decode, stall test, target proximity.
// ----------------------------------------------------------------------------
module gsd_front (
  input  logic               [1:0]  op,
  input  logic               [7:0]  command_byte,
  input  logic signed        [31:0] sample_position,
  input  logic signed        [31:0] sample_velocity,
  input  logic signed        [15:0] sample_current,
  input  gsd_pkg::cfg_t             cfg,
  output gsd_pkg::item_t            item
);
  import gsd_pkg::*;

  // |pos - target| < tol, evaluated at 33 bits so nothing wraps
  function automatic logic near_target(input logic [31:0] pos, input logic [31:0] target,
                                       input logic [11:0] tol);
    logic [32:0] diff;
    logic [32:0] span;
    diff = {pos[31], pos} - {target[31], target};
    span = diff[32] ? (~diff + 33'd1) : diff;
    return span < {21'd0, tol};
  endfunction

  logic [15:0] cur_mag;
  logic        vel_still;
  logic        margin_hit;
  logic        limit_hit;

  always_comb begin
    cur_mag   = sample_current[15] ? (~sample_current + 16'd1) : sample_current;
    vel_still = (sample_velocity > -32'sd3) && (sample_velocity < 32'sd3);
    limit_hit = cur_mag >= {5'd0, cfg.stall_current_limit};
    // a close current below the margin makes the threshold negative: always met
    if (cfg.close_current < STALL_CURRENT_MARGIN) begin
      margin_hit = 1'b1;
    end else begin
      margin_hit = cur_mag >= {5'd0, cfg.close_current - STALL_CURRENT_MARGIN};
    end

    item.stall      = limit_hit || (vel_still && margin_hit);
    item.near_open  = near_target(sample_position, cfg.open_position,
                                  cfg.position_tolerance);
    item.near_close = near_target(sample_position, cfg.close_position,
                                  cfg.position_tolerance);
    item.position   = sample_position;

    case (op_t'(op))
      OP_COMMAND: begin
        if (command_byte == CMD_OPEN) begin
          item.kind = KIND_OPEN_CMD;
        end else if (command_byte == CMD_CLOSE) begin
          item.kind = KIND_CLOSE_CMD;
        end else begin
          item.kind = KIND_OTHER_CMD;
        end
      end
      OP_SAMPLE: item.kind = KIND_SAMPLE;
      OP_TICK:   item.kind = KIND_TICK;
      default:   item.kind = KIND_NONE;
    endcase
  end

endmodule

// File: hdl/gsd_back.sv
// ----------------------------------------------------------------------------
// gsd_back
// Gripper sequencer: open/close phases, stall run, tick timeouts.
// ----------------------------------------------------------------------------
module gsd_back (
  input  logic              clk,
  input  logic              rst,
  input  gsd_pkg::cfg_t     cfg,
  input  logic              item_empty,
  input  gsd_pkg::item_t    item,
  output logic              item_pop,
  input  logic              res_full,
  output logic              res_push,
  output gsd_pkg::result_t  res
);
  import gsd_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] elapsed;
  logic [15:0] elapsed_next;
  logic [1:0]  stall_run;
  logic [1:0]  stall_run_next;
  logic [15:0] tick_count;
  logic [15:0] tick_limit;
  logic [1:0]  run_inc;
  logic        fire;

  assign fire     = !item_empty && !res_full;
  assign item_pop = fire;
  assign res_push = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      elapsed   <= '0;
      stall_run <= '0;
    end else if (fire) begin
      mode      <= mode_next;
      elapsed   <= elapsed_next;
      stall_run <= stall_run_next;
    end
  end

  always_comb begin
    mode_next      = mode;
    elapsed_next   = elapsed;
    stall_run_next = stall_run;
    res            = '0;
    res.event_code = EV_NONE;
    tick_count     = (elapsed == TICK_MAX) ? elapsed : elapsed + 16'd1;
    tick_limit     = (mode == MODE_OPENING) ? cfg.open_timeout_ms : cfg.close_timeout_ms;
    run_inc        = (stall_run == STALL_RUN_MAX) ? stall_run : stall_run + 2'd1;

    case (item.kind)
      KIND_OPEN_CMD: begin
        if (mode == MODE_IDLE || mode == MODE_CLOSING) begin
          mode_next         = MODE_OPENING;
          elapsed_next      = '0;
          res.write_valid   = 1'b1;
          res.goal_current  = cfg.hold_current;
          res.goal_position = cfg.open_position;
          res.event_code    = EV_OPEN_START;
        end
      end
      KIND_CLOSE_CMD: begin
        if (mode == MODE_IDLE) begin
          mode_next         = MODE_CLOSING;
          elapsed_next      = '0;
          stall_run_next    = '0;
          res.write_valid   = 1'b1;
          res.goal_current  = cfg.close_current;
          res.goal_position = cfg.close_position;
          res.event_code    = EV_CLOSE_START;
        end
      end
      KIND_SAMPLE: begin
        if (mode == MODE_OPENING) begin
          if (item.near_open) begin
            mode_next      = MODE_IDLE;
            res.event_code = EV_OPENED;
          end
        end else if (mode == MODE_CLOSING) begin
          stall_run_next = item.stall ? run_inc : 2'd0;
          // second stall in a row wins over the close target
          if (item.stall && run_inc > 2'd1) begin
            mode_next         = MODE_IDLE;
            res.write_valid   = 1'b1;
            res.goal_current  = cfg.hold_current;
            res.goal_position = item.position;
            res.event_code    = EV_STALL_HOLD;
          end else if (item.near_close) begin
            mode_next         = MODE_OPENING;
            elapsed_next      = '0;
            res.write_valid   = 1'b1;
            res.goal_current  = cfg.hold_current;
            res.goal_position = cfg.open_position;
            res.event_code    = EV_CLOSED_REOPEN;
          end
        end
      end
      KIND_TICK: begin
        if (mode != MODE_IDLE) begin
          elapsed_next = tick_count;
          if (tick_count >= tick_limit) begin
            mode_next      = MODE_IDLE;
            res.event_code = (mode == MODE_OPENING) ? EV_OPEN_TIMEOUT : EV_CLOSE_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase

    res.mode_now = mode_next;
  end

endmodule

// File: hdl/gripper_stall_detect_controller.sv
// Each item is registered in the item queue; the sequencer then registers its
// result in the result queue. Throughput: the sequencer takes one queued item
// per cycle while the result queue has room, and that queue lets pushes go on
// while a result waits for pop. Reset (rst, synchronous): both queues empty,
// mode idle, tick count and stall run zero, config registers back to defaults.
// ----------------------------------------------------------------------------
// gripper_stall_detect_controller
// Top level: configuration registers, classifier, item queue, sequencer and
// result queue.
// ----------------------------------------------------------------------------
module gripper_stall_detect_controller #(
  parameter int ITEM_DEPTH   = 4,
  parameter int RESULT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data,
  input  logic               push,
  output logic               full,
  input  logic        [1:0]  op,
  input  logic        [7:0]  command_byte,
  input  logic signed [31:0] sample_position,
  input  logic signed [31:0] sample_velocity,
  input  logic signed [15:0] sample_current,
  output logic               empty,
  input  logic               pop,
  output logic               write_valid,
  output logic        [10:0] goal_current,
  output logic signed [31:0] goal_position,
  output logic        [1:0]  mode_now,
  output logic        [2:0]  event_code
);
  import gsd_pkg::*;

  cfg_t    cfg;
  item_t   front_item;
  item_t   head_item;
  logic    item_empty;
  logic    item_pop;
  logic    res_full;
  logic    res_push;
  result_t back_res;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.close_current       <= RST_CLOSE_CURRENT;
      cfg.hold_current        <= RST_HOLD_CURRENT;
      cfg.open_position       <= RST_OPEN_POSITION;
      cfg.close_position      <= RST_CLOSE_POSITION;
      cfg.position_tolerance  <= RST_POSITION_TOLERANCE;
      cfg.stall_current_limit <= RST_STALL_CURRENT;
      cfg.open_timeout_ms     <= RST_OPEN_TIMEOUT;
      cfg.close_timeout_ms    <= RST_CLOSE_TIMEOUT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLOSE_CURRENT:      cfg.close_current       <= cfg_data[10:0];
        REG_HOLD_CURRENT:       cfg.hold_current        <= cfg_data[10:0];
        REG_OPEN_POSITION:      cfg.open_position       <= cfg_data;
        REG_CLOSE_POSITION:     cfg.close_position      <= cfg_data;
        REG_POSITION_TOLERANCE: cfg.position_tolerance  <= cfg_data[11:0];
        REG_STALL_CURRENT:      cfg.stall_current_limit <= cfg_data[10:0];
        REG_OPEN_TIMEOUT:       cfg.open_timeout_ms     <= cfg_data[15:0];
        REG_CLOSE_TIMEOUT:      cfg.close_timeout_ms    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  gsd_front u_front (
    .op              (op),
    .command_byte    (command_byte),
    .sample_position (sample_position),
    .sample_velocity (sample_velocity),
    .sample_current  (sample_current),
    .cfg             (cfg),
    .item            (front_item)
  );

  gsd_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (ITEM_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (front_item),
    .pop   (item_pop),
    .empty (item_empty),
    .dout  (head_item)
  );

  gsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_empty (item_empty),
    .item       (head_item),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  gsd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (back_res),
    .pop   (pop),
    .empty (empty),
    .dout  (out_res)
  );

  assign write_valid   = out_res.write_valid;
  assign goal_current  = out_res.goal_current;
  assign goal_position = out_res.goal_position;
  assign mode_now      = out_res.mode_now;
  assign event_code    = out_res.event_code;

endmodule

// File: hdl/gsd_checker.sv
// ----------------------------------------------------------------------------
// gsd_checker
// Port-level checks for the gripper stall-detect controller.
// ----------------------------------------------------------------------------
module gsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        write_valid,
  input logic [10:0] goal_current,
  input logic [31:0] goal_position,
  input logic [1:0]  mode_now,
  input logic [2:0]  event_code
);
  import gsd_pkg::*;

  // after reset the result queue is empty and the item queue is not full
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a waiting result holds until transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(goal_position) && $stable(event_code)
                          && $stable(write_valid) && $stable(mode_now)))
    else $error("waiting result changed before transfer");

  // no goal is shown without a write
  a_goal_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !write_valid) |-> (goal_current == '0 && goal_position == '0))
    else $error("goal fields set without write_valid");

  // open starts and reopens write a goal and enter opening mode
  a_start_mode: assert property (@(posedge clk) disable iff (rst)
    (!empty && (event_code == EV_OPEN_START || event_code == EV_CLOSED_REOPEN))
      |-> (write_valid && mode_now == MODE_OPENING))
    else $error("open start without write or opening mode");

  // ending events land in idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (!empty && (event_code == EV_OPENED || event_code == EV_OPEN_TIMEOUT ||
                event_code == EV_STALL_HOLD || event_code == EV_CLOSE_TIMEOUT))
      |-> (mode_now == MODE_IDLE))
    else $error("ending event without idle mode");

endmodule

bind gripper_stall_detect_controller gsd_checker u_gsd_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .write_valid   (write_valid),
  .goal_current  (goal_current),
  .goal_position (goal_position),
  .mode_now      (mode_now),
  .event_code    (event_code)
);
